@@ rtl/rti_pkg.sv @@
`default_nettype none
package rti_pkg;

    // Fixed field widths
    localparam int DIR_W   = 18;
    localparam int RANGE_W = 31;
    localparam int EPS_W   = 32;
    localparam int TAG_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd2814749767;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_DIR_X       = 3'd3,
        CFG_DIR_Y       = 3'd4,
        CFG_DIR_Z       = 3'd5,
        CFG_MAX_RANGE   = 3'd6,
        CFG_DET_EPSILON = 3'd7
    } cfg_idx_t;

    // Control that travels with each transaction
    typedef struct packed {
        logic             valid;
        logic             reject;
        logic [TAG_W-1:0] tag;
    } ctl_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Width of the determinant: e1 . (dir x e2)
    function automatic int det_w(input int cw);
        return 2 * (cw + 1) + DIR_W + 3;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rti_mul.sv @@
`default_nettype none
module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [AW-1:0]  a,
    input  wire logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0]    prod
);

    localparam int LW = BW / 2;
    localparam int HW = BW - LW;

    logic signed [AW+LW:0]    lo_reg;
    logic signed [AW+HW-1:0]  hi_reg;
    logic signed [AW+BW-1:0]  prod_reg;

    // Form the two partial products on the low and high halves of b
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= a * $signed({1'b0, b[LW-1:0]});
            hi_reg <= a * $signed(b[BW-1:LW]);
        end
    end

    // Recombine the partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= $signed({hi_reg, {LW{1'b0}}}) + (AW+BW)'(lo_reg);
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ rtl/rti_geom.sv @@
`default_nettype none
module rti_geom #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [CW-1:0]          v0_x,
    input  wire logic signed [CW-1:0]          v0_y,
    input  wire logic signed [CW-1:0]          v0_z,
    input  wire logic signed [CW-1:0]          v1_x,
    input  wire logic signed [CW-1:0]          v1_y,
    input  wire logic signed [CW-1:0]          v1_z,
    input  wire logic signed [CW-1:0]          v2_x,
    input  wire logic signed [CW-1:0]          v2_y,
    input  wire logic signed [CW-1:0]          v2_z,
    input  wire logic [rti_pkg::TAG_W-1:0]     tri_tag,
    input  wire logic signed [CW-1:0]          origin_x,
    input  wire logic signed [CW-1:0]          origin_y,
    input  wire logic signed [CW-1:0]          origin_z,
    input  wire logic signed [rti_pkg::DIR_W-1:0] dir_x,
    input  wire logic signed [rti_pkg::DIR_W-1:0] dir_y,
    input  wire logic signed [rti_pkg::DIR_W-1:0] dir_z,
    input  wire logic [rti_pkg::EPS_W-1:0]     det_epsilon,
    output rti_pkg::ctl_t                      ctl_out,
    output logic [rti_pkg::det_w(CW)-1:0]      det_out,
    output logic [rti_pkg::det_w(CW)-1:0]      rem_out,
    output logic [rti_pkg::RANGE_W-1:0]        low_out
);

    localparam int DW   = rti_pkg::DIR_W;
    localparam int EW   = CW + 1;
    localparam int PW   = DW + EW + 1;
    localparam int QW   = 2 * EW + 1;
    localparam int DETW = rti_pkg::det_w(CW);
    localparam int VNW  = DW + QW + 2;
    localparam int RNW  = EW + QW + 2;
    localparam int RW   = rti_pkg::RANGE_W;
    localparam int RSW  = RNW + 1 + FB;
    localparam int HIW  = RSW - RW;
    localparam int CMPW = rti_pkg::imax(HIW, DETW);
    localparam int CMPE = rti_pkg::imax(DETW, rti_pkg::EPS_W);
    localparam int SW   = rti_pkg::imax(DETW + 1, VNW + 1) + 1;
    localparam int NS   = 9;

    logic signed [CW-1:0] v0a [3];
    logic signed [CW-1:0] v1a [3];
    logic signed [CW-1:0] v2a [3];
    logic signed [CW-1:0] oa  [3];
    logic signed [DW-1:0] da  [3];

    assign v0a = '{v0_x, v0_y, v0_z};
    assign v1a = '{v1_x, v1_y, v1_z};
    assign v2a = '{v2_x, v2_y, v2_z};
    assign oa  = '{origin_x, origin_y, origin_z};
    assign da  = '{dir_x, dir_y, dir_z};

    // Valid and tag travel alongside the data
    logic [NS-1:0]             vld_reg;
    logic [rti_pkg::TAG_W-1:0] tag_reg [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tri_tag;
            for (int k = 1; k < NS; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Stage 1: edges and origin offset; stages 2 to 4: delay them for the dots
    logic signed [EW-1:0] e1_s1 [3];
    logic signed [EW-1:0] e2_s1 [3];
    logic signed [EW-1:0] t_s1  [3];
    logic signed [EW-1:0] e1_s2 [3];
    logic signed [EW-1:0] e2_s2 [3];
    logic signed [EW-1:0] t_s2  [3];
    logic signed [EW-1:0] e1_s3 [3];
    logic signed [EW-1:0] e2_s3 [3];
    logic signed [EW-1:0] t_s3  [3];
    logic signed [EW-1:0] e1_s4 [3];
    logic signed [EW-1:0] e2_s4 [3];
    logic signed [EW-1:0] t_s4  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_s1[i] <= EW'(v1a[i]) - EW'(v0a[i]);
                e2_s1[i] <= EW'(v2a[i]) - EW'(v0a[i]);
                t_s1[i]  <= EW'(oa[i]) - EW'(v0a[i]);
                e1_s2[i] <= e1_s1[i];
                e2_s2[i] <= e2_s1[i];
                t_s2[i]  <= t_s1[i];
                e1_s3[i] <= e1_s2[i];
                e2_s3[i] <= e2_s2[i];
                t_s3[i]  <= t_s2[i];
                e1_s4[i] <= e1_s3[i];
                e2_s4[i] <= e2_s3[i];
                t_s4[i]  <= t_s3[i];
            end
        end
    end

    // Stages 2 and 3: cross product terms p = dir x e2, q = t x e1
    logic signed [DW+EW-1:0] pa_prod [3];
    logic signed [DW+EW-1:0] pb_prod [3];
    logic signed [2*EW-1:0]  qa_prod [3];
    logic signed [2*EW-1:0]  qb_prod [3];
    logic signed [PW-1:0]    p_s4 [3];
    logic signed [QW-1:0]    q_s4 [3];

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_cross
        localparam int J = (gi + 1) % 3;
        localparam int K = (gi + 2) % 3;

        rti_mul #(.AW(DW), .BW(EW)) u_pa (
            .clk(clk), .en(en), .a(da[J]), .b(e2_s1[K]), .prod(pa_prod[gi]));
        rti_mul #(.AW(DW), .BW(EW)) u_pb (
            .clk(clk), .en(en), .a(da[K]), .b(e2_s1[J]), .prod(pb_prod[gi]));
        rti_mul #(.AW(EW), .BW(EW)) u_qa (
            .clk(clk), .en(en), .a(t_s1[J]), .b(e1_s1[K]), .prod(qa_prod[gi]));
        rti_mul #(.AW(EW), .BW(EW)) u_qb (
            .clk(clk), .en(en), .a(t_s1[K]), .b(e1_s1[J]), .prod(qb_prod[gi]));
    end

    // Stage 4: cross product differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_s4[i] <= PW'(pa_prod[i]) - PW'(pb_prod[i]);
                q_s4[i] <= QW'(qa_prod[i]) - QW'(qb_prod[i]);
            end
        end
    end

    // Stages 5 and 6: dot product terms
    logic signed [EW+PW-1:0] det_prod [3];
    logic signed [EW+PW-1:0] un_prod  [3];
    logic signed [DW+QW-1:0] vn_prod  [3];
    logic signed [EW+QW-1:0] rn_prod  [3];

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_dot
        rti_mul #(.AW(EW), .BW(PW)) u_det (
            .clk(clk), .en(en), .a(e1_s4[gi]), .b(p_s4[gi]), .prod(det_prod[gi]));
        rti_mul #(.AW(EW), .BW(PW)) u_un (
            .clk(clk), .en(en), .a(t_s4[gi]), .b(p_s4[gi]), .prod(un_prod[gi]));
        rti_mul #(.AW(DW), .BW(QW)) u_vn (
            .clk(clk), .en(en), .a(da[gi]), .b(q_s4[gi]), .prod(vn_prod[gi]));
        rti_mul #(.AW(EW), .BW(QW)) u_rn (
            .clk(clk), .en(en), .a(e2_s4[gi]), .b(q_s4[gi]), .prod(rn_prod[gi]));
    end

    // Stage 7: sum the dot product terms
    logic signed [DETW-1:0] det_s7;
    logic signed [DETW-1:0] un_s7;
    logic signed [VNW-1:0]  vn_s7;
    logic signed [RNW-1:0]  rn_s7;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_s7 <= DETW'(det_prod[0]) + DETW'(det_prod[1]) + DETW'(det_prod[2]);
            un_s7  <= DETW'(un_prod[0]) + DETW'(un_prod[1]) + DETW'(un_prod[2]);
            vn_s7  <= VNW'(vn_prod[0]) + VNW'(vn_prod[1]) + VNW'(vn_prod[2]);
            rn_s7  <= RNW'(rn_prod[0]) + RNW'(rn_prod[1]) + RNW'(rn_prod[2]);
        end
    end

    // Stage 8: fold the sign of det into the numerators
    logic                     det_neg;
    logic [DETW-1:0]          det_s8;
    logic signed [DETW:0]     un_s8;
    logic signed [VNW:0]      vn_s8;
    logic signed [RNW:0]      rn_s8;

    assign det_neg = det_s7[DETW-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_s8 <= det_neg ? DETW'(-det_s7) : DETW'(det_s7);
            un_s8  <= det_neg ? -(DETW+1)'(un_s7) : (DETW+1)'(un_s7);
            vn_s8  <= det_neg ? -(VNW+1)'(vn_s7) : (VNW+1)'(vn_s7);
            rn_s8  <= det_neg ? -(RNW+1)'(rn_s7) : (RNW+1)'(rn_s7);
        end
    end

    // Stage 9: rejection tests and setup of the range division
    logic signed [DETW:0]  det_sx;
    logic signed [SW-1:0]  uv_sum;
    logic [RSW-1:0]        rs;
    logic [HIW-1:0]        rs_hi;
    logic                  rej_parallel;
    logic                  rej_bary;
    logic                  rej_range;
    logic                  rej_s9_reg;
    logic [DETW-1:0]       det_s9_reg;
    logic [DETW-1:0]       rem_s9_reg;
    logic [RW-1:0]         low_s9_reg;

    always_comb
    begin
        det_sx       = $signed({1'b0, det_s8});
        uv_sum       = SW'(un_s8) + SW'(vn_s8);
        rs           = {rn_s8, {FB{1'b0}}};
        rs_hi        = rs[RSW-1:RW];
        rej_parallel = (det_s8 == '0) || (CMPE'(det_s8) < CMPE'(det_epsilon));
        rej_bary     = un_s8[DETW] || (un_s8 > det_sx) || vn_s8[VNW]
                       || (uv_sum > SW'(det_sx));
        rej_range    = rn_s8[RNW] || (CMPW'(rs_hi) >= CMPW'(det_s8));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rej_s9_reg <= rej_parallel || rej_bary || rej_range;
            det_s9_reg <= det_s8;
            rem_s9_reg <= DETW'(rs_hi);
            low_s9_reg <= rs[RW-1:0];
        end
    end

    assign ctl_out.valid  = vld_reg[NS-1];
    assign ctl_out.reject = rej_s9_reg;
    assign ctl_out.tag    = tag_reg[NS-1];
    assign det_out        = det_s9_reg;
    assign rem_out        = rem_s9_reg;
    assign low_out        = low_s9_reg;

endmodule
`default_nettype wire

@@ rtl/rti_div_step.sv @@
`default_nettype none
module rti_div_step #(
    parameter int DETW = 87
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire rti_pkg::ctl_t                 ctl_in,
    input  wire logic [DETW-1:0]               det_in,
    input  wire logic [DETW-1:0]               rem_in,
    input  wire logic [rti_pkg::RANGE_W-1:0]   low_in,
    input  wire logic [rti_pkg::RANGE_W-1:0]   quo_in,
    output rti_pkg::ctl_t                      ctl_out,
    output logic [DETW-1:0]                    det_out,
    output logic [DETW-1:0]                    rem_out,
    output logic [rti_pkg::RANGE_W-1:0]        low_out,
    output logic [rti_pkg::RANGE_W-1:0]        quo_out
);

    localparam int RW = rti_pkg::RANGE_W;

    logic [DETW:0]             trial;
    logic                      fits;
    logic                      vld_reg;
    logic                      rej_reg;
    logic [rti_pkg::TAG_W-1:0] tag_reg;
    logic [DETW-1:0]           det_reg;
    logic [DETW-1:0]           rem_reg;
    logic [RW-1:0]             low_reg;
    logic [RW-1:0]             quo_reg;

    // Bring down the next dividend bit and try one subtraction
    assign trial = {rem_in, low_in[RW-1]};
    assign fits  = trial >= {1'b0, det_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rej_reg <= ctl_in.reject;
            tag_reg <= ctl_in.tag;
            det_reg <= det_in;
            rem_reg <= fits ? DETW'(trial - {1'b0, det_in}) : DETW'(trial);
            low_reg <= {low_in[RW-2:0], 1'b0};
            quo_reg <= {quo_in[RW-2:0], fits};
        end
    end

    assign ctl_out.valid  = vld_reg;
    assign ctl_out.reject = rej_reg;
    assign ctl_out.tag    = tag_reg;
    assign det_out        = det_reg;
    assign rem_out        = rem_reg;
    assign low_out        = low_reg;
    assign quo_out        = quo_reg;

endmodule
`default_nettype wire

@@ rtl/ray_triangle_intersect.sv @@
// Throughput: one triangle per cycle while in_stall is low; 9 stages of geometry
// (edges, cross and dot products as split multipliers, sign fold, tests) and 31
// one-bit divider stages.
// A two-entry output (register plus skid) lets the pipeline run on while a result waits.
// Reset clears all valid bits and loads the ray registers with their defaults.
`default_nettype none
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [rti_pkg::IDX_W-1:0]              cfg_index,
    input  wire logic [rti_pkg::imax(COORD_WIDTH, 32)-1:0] cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]          v0_x,
    input  wire logic signed [COORD_WIDTH-1:0]          v0_y,
    input  wire logic signed [COORD_WIDTH-1:0]          v0_z,
    input  wire logic signed [COORD_WIDTH-1:0]          v1_x,
    input  wire logic signed [COORD_WIDTH-1:0]          v1_y,
    input  wire logic signed [COORD_WIDTH-1:0]          v1_z,
    input  wire logic signed [COORD_WIDTH-1:0]          v2_x,
    input  wire logic signed [COORD_WIDTH-1:0]          v2_y,
    input  wire logic signed [COORD_WIDTH-1:0]          v2_z,
    input  wire logic [rti_pkg::TAG_W-1:0]              tri_tag,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        hit,
    output logic [rti_pkg::RANGE_W-1:0]                 hit_range,
    output logic [rti_pkg::TAG_W-1:0]                   tag_out
);

    localparam int DW   = rti_pkg::DIR_W;
    localparam int RW   = rti_pkg::RANGE_W;
    localparam int TW   = rti_pkg::TAG_W;
    localparam int EPW  = rti_pkg::EPS_W;
    localparam int DETW = rti_pkg::det_w(COORD_WIDTH);

    // Ray configuration
    logic signed [COORD_WIDTH-1:0] origin_x_reg;
    logic signed [COORD_WIDTH-1:0] origin_y_reg;
    logic signed [COORD_WIDTH-1:0] origin_z_reg;
    logic signed [DW-1:0]          dir_x_reg;
    logic signed [DW-1:0]          dir_y_reg;
    logic signed [DW-1:0]          dir_z_reg;
    logic [RW-1:0]                 range_limit_reg;
    logic [EPW-1:0]                det_epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            dir_x_reg       <= DW'(1) << FRAC_BITS;
            dir_y_reg       <= '0;
            dir_z_reg       <= '0;
            range_limit_reg <= '1;
            det_epsilon_reg <= rti_pkg::EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rti_pkg::cfg_idx_t'(cfg_index))
                rti_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_data[COORD_WIDTH-1:0];
                rti_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data[COORD_WIDTH-1:0];
                rti_pkg::CFG_ORIGIN_Z:    origin_z_reg    <= cfg_data[COORD_WIDTH-1:0];
                rti_pkg::CFG_DIR_X:       dir_x_reg       <= cfg_data[DW-1:0];
                rti_pkg::CFG_DIR_Y:       dir_y_reg       <= cfg_data[DW-1:0];
                rti_pkg::CFG_DIR_Z:       dir_z_reg       <= cfg_data[DW-1:0];
                rti_pkg::CFG_MAX_RANGE:   range_limit_reg <= cfg_data[RW-1:0];
                rti_pkg::CFG_DET_EPSILON: det_epsilon_reg <= cfg_data[EPW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances while the skid entry is free
    logic out_vld_reg;
    logic skid_vld_reg;
    logic en;

    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    // Geometry stages
    rti_pkg::ctl_t ch_ctl [RW+1];
    logic [DETW-1:0] ch_det [RW+1];
    logic [DETW-1:0] ch_rem [RW+1];
    logic [RW-1:0]   ch_low [RW+1];
    logic [RW-1:0]   ch_quo [RW+1];

    rti_geom #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_geom (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
        .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
        .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
        .tri_tag(tri_tag),
        .origin_x(origin_x_reg), .origin_y(origin_y_reg), .origin_z(origin_z_reg),
        .dir_x(dir_x_reg), .dir_y(dir_y_reg), .dir_z(dir_z_reg),
        .det_epsilon(det_epsilon_reg),
        .ctl_out(ch_ctl[0]), .det_out(ch_det[0]), .rem_out(ch_rem[0]),
        .low_out(ch_low[0])
    );

    assign ch_quo[0] = '0;

    // Range quotient, one bit per stage
    for (genvar gk = 0; gk < RW; gk++)
    begin : g_div
        rti_div_step #(.DETW(DETW)) u_step (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(ch_ctl[gk]), .det_in(ch_det[gk]), .rem_in(ch_rem[gk]),
            .low_in(ch_low[gk]), .quo_in(ch_quo[gk]),
            .ctl_out(ch_ctl[gk+1]), .det_out(ch_det[gk+1]), .rem_out(ch_rem[gk+1]),
            .low_out(ch_low[gk+1]), .quo_out(ch_quo[gk+1])
        );
    end

    // Final decision on the quotient
    logic          last_vld;
    logic          last_hit;
    logic [RW-1:0] last_range;

    assign last_vld   = ch_ctl[RW].valid;
    assign last_hit   = !ch_ctl[RW].reject && (ch_quo[RW] != '0)
                        && (ch_quo[RW] <= range_limit_reg);
    assign last_range = last_hit ? ch_quo[RW] : '0;

    // Output register and skid entry
    logic          out_ready;
    logic          out_hit_reg;
    logic [RW-1:0] out_range_reg;
    logic [TW-1:0] out_tag_reg;
    logic          skid_hit_reg;
    logic [RW-1:0] skid_range_reg;
    logic [TW-1:0] skid_tag_reg;

    assign out_ready = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_vld_reg  <= skid_vld_reg || last_vld;
            skid_vld_reg <= 1'b0;
        end
        else if (last_vld && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_hit_reg   <= skid_vld_reg ? skid_hit_reg : last_hit;
            out_range_reg <= skid_vld_reg ? skid_range_reg : last_range;
            out_tag_reg   <= skid_vld_reg ? skid_tag_reg : ch_ctl[RW].tag;
        end
        else if (en)
        begin
            skid_hit_reg   <= last_hit;
            skid_range_reg <= last_range;
            skid_tag_reg   <= ch_ctl[RW].tag;
        end
    end

    assign out_valid = out_vld_reg;
    assign hit       = out_hit_reg;
    assign hit_range = out_range_reg;
    assign tag_out   = out_tag_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry holds data while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && out_stall))
        else $error("skid entry filled without a stalled output");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (hit_range != '0) && (hit_range <= range_limit_reg))
        else $error("hit distance outside 1..range limit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_range == '0)
        else $error("miss carries a nonzero distance");
`endif

endmodule
`default_nettype wire

@@ tb/ray_triangle_intersect_test.sv @@
`default_nettype none
module ray_triangle_intersect_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int ONE    = 1 << FB;
    localparam int PHASES = 8;
    localparam int RANDOM_PER_PHASE = 180;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [CW-1:0]        vtx [9];
        logic [rti_pkg::TAG_W-1:0]   tag;
        bit                          typed;
        logic                        exp_hit;
        logic [rti_pkg::RANGE_W-1:0] exp_range;
    } tri_row_t;

    typedef struct {
        logic                        hit;
        logic [rti_pkg::RANGE_W-1:0] range;
        logic [rti_pkg::TAG_W-1:0]   tag;
    } hit_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [rti_pkg::IDX_W-1:0]   cfg_index;
    logic [31:0]                 cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [CW-1:0]        vin [9];
    logic [rti_pkg::TAG_W-1:0]   tri_tag;
    logic                        out_valid;
    logic                        out_stall;
    logic                        hit;
    logic [rti_pkg::RANGE_W-1:0] hit_range;
    logic [rti_pkg::TAG_W-1:0]   tag_out;

    // Ray as currently programmed
    logic signed [CW-1:0]             ray_org [3];
    logic signed [rti_pkg::DIR_W-1:0] ray_dir [3];
    logic [rti_pkg::RANGE_W-1:0]      ray_max;
    logic [rti_pkg::EPS_W-1:0]        ray_eps;

    hit_result_t pending_hits [$];
    tri_row_t    directed_rows [$];
    int          errors;
    int          sent_count;
    int          hit_count;
    int          checked_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          holdoff_requests;
    int          holdoff_served;
    int          holdoff_left;

    ray_triangle_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
        .v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
        .v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
        .tri_tag(tri_tag),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_range(hit_range), .tag_out(tag_out)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Exact fixed-point intersection of the programmed ray with one triangle
    function automatic hit_result_t predict_hit(tri_row_t t);
        wide_t o [3], d [3], e1 [3], e2 [3], tv [3], p [3], q [3];
        wide_t det, un, vn, rn, rs, lim;
        hit_result_t r;
        for (int i = 0; i < 3; i++)
        begin
            o[i]  = wide_t'(ray_org[i]);
            d[i]  = wide_t'(ray_dir[i]);
            e1[i] = wide_t'(t.vtx[3+i]) - wide_t'(t.vtx[i]);
            e2[i] = wide_t'(t.vtx[6+i]) - wide_t'(t.vtx[i]);
            tv[i] = o[i] - wide_t'(t.vtx[i]);
        end
        p[0] = d[1]*e2[2] - d[2]*e2[1];
        p[1] = d[2]*e2[0] - d[0]*e2[2];
        p[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0] = tv[1]*e1[2] - tv[2]*e1[1];
        q[1] = tv[2]*e1[0] - tv[0]*e1[2];
        q[2] = tv[0]*e1[1] - tv[1]*e1[0];
        det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
        un  = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
        vn  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        rn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        // fold the determinant sign into the numerators
        if (det < 0)
        begin
            det = -det;
            un  = -un;
            vn  = -vn;
            rn  = -rn;
        end
        rs  = rn * wide_t'(ONE);
        lim = det * (wide_t'(ray_max) + 1);
        r.hit   = 1'b0;
        r.range = '0;
        r.tag   = t.tag;
        if (det == 0 || det < wide_t'(ray_eps))
            r.hit = 1'b0;
        else if (un < 0 || un > det || vn < 0 || un + vn > det)
            r.hit = 1'b0;
        else if (rs < det || rs >= lim)
            r.hit = 1'b0;
        else
        begin
            r.hit   = 1'b1;
            r.range = rti_pkg::RANGE_W'(rs / det);
        end
        return r;
    endfunction

    function automatic tri_row_t unit_tri(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz,
                                          logic [rti_pkg::TAG_W-1:0] tag);
        tri_row_t t;
        int c [9];
        c = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        for (int i = 0; i < 9; i++)
            t.vtx[i] = CW'(c[i] * ONE);
        t.tag       = tag;
        t.typed     = 1'b0;
        t.exp_hit   = 1'b0;
        t.exp_range = '0;
        return t;
    endfunction

    function automatic tri_row_t typed(tri_row_t t, logic h,
                                       logic [rti_pkg::RANGE_W-1:0] r);
        t.typed     = 1'b1;
        t.exp_hit   = h;
        t.exp_range = r;
        return t;
    endfunction

    function automatic tri_row_t all_vtx(tri_row_t t, logic [CW-1:0] a, logic [CW-1:0] b);
        for (int i = 0; i < 9; i++)
            t.vtx[i] = (i < 3 || i >= 6) ? a : b;
        return t;
    endfunction

    function automatic void add_row(tri_row_t t);
        directed_rows.insert(directed_rows.size(), t);
    endfunction

    // Triangle built around a point on the ray, so most of these hit
    function automatic tri_row_t aimed_tri();
        tri_row_t t;
        longint s, spread, pnt, a, b;
        s      = $urandom_range(1, 1 << 22);
        spread = ($urandom_range(3) == 0) ? (1 << 24) : (1 << 18);
        for (int i = 0; i < 3; i++)
        begin
            pnt = longint'(ray_org[i]) + ((s * longint'(ray_dir[i])) >>> FB);
            a   = longint'($urandom_range(0, 32'(2*spread))) - spread;
            b   = longint'($urandom_range(0, 32'(2*spread))) - spread;
            t.vtx[i]   = CW'(pnt + a);
            t.vtx[3+i] = CW'(pnt + b);
            t.vtx[6+i] = CW'(pnt - a - b);
        end
        t.tag   = $urandom;
        t.typed = 1'b0;
        return t;
    endfunction

    function automatic tri_row_t noise_tri();
        tri_row_t t;
        bit wide_noise;
        wide_noise = $urandom_range(1);
        for (int i = 0; i < 9; i++)
            t.vtx[i] = wide_noise ? CW'($urandom)
                                  : CW'(ray_org[i%3] + $urandom_range(0, 1 << 22) - (1 << 21));
        t.tag   = $urandom;
        t.typed = 1'b0;
        return t;
    endfunction

    task automatic write_reg(rti_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            rti_pkg::CFG_ORIGIN_X:    ray_org[0] = value;
            rti_pkg::CFG_ORIGIN_Y:    ray_org[1] = value;
            rti_pkg::CFG_ORIGIN_Z:    ray_org[2] = value;
            rti_pkg::CFG_DIR_X:       ray_dir[0] = value[rti_pkg::DIR_W-1:0];
            rti_pkg::CFG_DIR_Y:       ray_dir[1] = value[rti_pkg::DIR_W-1:0];
            rti_pkg::CFG_DIR_Z:       ray_dir[2] = value[rti_pkg::DIR_W-1:0];
            rti_pkg::CFG_MAX_RANGE:   ray_max    = value[rti_pkg::RANGE_W-1:0];
            rti_pkg::CFG_DET_EPSILON: ray_eps    = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_ray(int ph);
        logic [31:0] v [8];
        case (ph)
            1: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     -ONE, 0, 0, 0, 0};
            2: v = '{32'h80000000, 32'h80000000, 32'h80000000,
                     0, ONE, 0, 32'h7fffffff, 32'hffffffff};
            3: v = '{0, 0, 0, 0, 0, -ONE, 1000 * ONE, 0};
            default:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = $urandom_range(0, 1 << 25) - (1 << 24);
                for (int i = 3; i < 6; i++)
                    v[i] = $urandom_range(0, 2*ONE) - ONE;
                v[6] = $urandom_range(0, 32'h7fffffff);
                v[7] = $urandom_range(0, 1 << 20);
            end
        endcase
        // let the pipeline drain before touching the ray
        wait (pending_hits.size() == 0);
        repeat (45) @(posedge clk);
        for (int i = 0; i < 8; i++)
            write_reg(rti_pkg::cfg_idx_t'(i), v[i]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tri(tri_row_t t);
        hit_result_t r;
        // idle the sender at random before each triangle
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
            vin[i] <= t.vtx[i];
        tri_tag <= t.tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (t.typed)
        begin
            r.hit   = t.exp_hit;
            r.range = t.exp_range;
            r.tag   = t.tag;
        end
        else
            r = predict_hit(t);
        pending_hits.insert(pending_hits.size(), r);
        sent_count++;
    endtask

    // Receiver stall, including the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            holdoff_left   <= 0;
            holdoff_served <= 0;
        end
        else if (holdoff_served != holdoff_requests)
        begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= 400;
            out_stall      <= 1'b1;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each result transaction with the oldest pending hit
    always @(posedge clk)
    begin
        hit_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result with tag %h arrived with none pending", tag_out);
                errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                checked_count++;
                if (hit)
                    hit_count++;
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    errors++;
                end
                if (hit_range !== want.range)
                begin
                    $error("hit_range: expected %0d, got %0d", want.range, hit_range);
                    errors++;
                end
                if (tag_out !== want.tag)
                begin
                    $error("tag_out: expected %h, got %h", want.tag, tag_out);
                    errors++;
                end
            end
        end
    end

    // Hard stop
    initial
    begin
        #20ms;
        $display("ray_triangle_intersect_test failed");
        $finish;
    end

    initial
    begin
        errors         = 0;
        sent_count     = 0;
        hit_count      = 0;
        checked_count  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_requests = 0;
        ray_org = '{0, 0, 0};
        ray_dir = '{rti_pkg::DIR_W'(ONE), '0, '0};
        ray_max = 31'h7fffffff;
        ray_eps = rti_pkg::EPS_RESET;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        tri_tag   = '0;
        for (int i = 0; i < 9; i++)
            vin[i] = '0;

        // Directed triangles against the reset ray (origin 0, +x)
        add_row(typed(unit_tri(5,-1,-1, 5,2,-1, 5,-1,2, 1), 1'b1, 31'(5 * ONE)));
        add_row(typed(unit_tri(5,-1,-1, 5,-1,2, 5,2,-1, 2), 1'b1, 31'(5 * ONE)));
        add_row(typed(unit_tri(-5,-1,-1, -5,2,-1, -5,-1,2, 3), 1'b0, '0));
        add_row(typed(unit_tri(5,9,-1, 5,12,-1, 5,9,2, 4), 1'b0, '0));
        add_row(typed(unit_tri(3,3,3, 3,3,3, 3,3,3, 5), 1'b0, '0));
        add_row(typed(unit_tri(0,-1,-1, 0,2,-1, 0,-1,2, 6), 1'b0, '0));
        add_row(typed(unit_tri(5,0,0, 5,1,1, 5,2,2, 7), 1'b0, '0));
        add_row(typed(unit_tri(30000,-1,-1, 30000,2,-1, 30000,-1,2,
                               32'hffffffff), 1'b1, 31'(30000 * ONE)));
        add_row(typed(unit_tri(1,0,-1, 9,0,-1, 1,0,3, 0), 1'b0, '0));
        add_row(typed(all_vtx(unit_tri(0,0,0, 0,0,0, 0,0,0, 8),
                              32'h7fffffff, 32'h7fffffff), 1'b0, '0));
        add_row(typed(all_vtx(unit_tri(0,0,0, 0,0,0, 0,0,0, 9),
                              32'h80000000, 32'h80000000), 1'b0, '0));
        // Tiny triangle: determinant far under the threshold
        begin
            tri_row_t tiny;
            tiny = unit_tri(5,0,0, 5,0,0, 5,0,0, 10);
            tiny.vtx[4] = tiny.vtx[4] + 1;
            tiny.vtx[8] = tiny.vtx[8] + 1;
            add_row(typed(tiny, 1'b0, '0));
        end
        add_row(unit_tri(5,0,-1, 5,2,-1, 5,0,2, 11));
        add_row(unit_tri(5,0,0, 5,2,0, 5,0,2, 12));
        add_row(unit_tri(5,1,-1, 5,1,2, 5,-2,1, 13));
        add_row(unit_tri(2,-1,-1, 3,2,-1, 3,-1,2, 14));
        add_row(all_vtx(unit_tri(0,0,0, 0,0,0, 0,0,0, 15),
                        32'h7fffffff, 32'h80000000));
        add_row(all_vtx(unit_tri(0,0,0, 0,0,0, 0,0,0, 16),
                        32'h80000000, 32'h7fffffff));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                program_ray(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (ph == 0)
                foreach (directed_rows[k])
                    send_tri(directed_rows[k]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // fill the pipeline against a stalled output
                if (ph == 2 && n == 40)
                    holdoff_requests++;
                // pause the sender until everything is back
                if (ph == 5 && n == 90)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait (pending_hits.size() == 0);
                    @(posedge clk);
                end
                send_tri(($urandom_range(99) < 75) ? aimed_tri() : noise_tri());
            end
            in_valid <= 1'b0;
        end

        wait (pending_hits.size() == 0);
        repeat (60) @(posedge clk);
        $display("Sent %0d triangles over %0d ray settings; %0d results checked, %0d hits.",
                 sent_count, PHASES, checked_count, hit_count);
        if (errors == 0)
            $display("ray_triangle_intersect_test passed");
        else
            $display("ray_triangle_intersect_test failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/rti_pkg.sv
rtl/rti_mul.sv
rtl/rti_geom.sv
rtl/rti_div_step.sv
rtl/ray_triangle_intersect.sv
tb/ray_triangle_intersect_test.sv
